// ===== hdl/tgi_pkg.sv =====
// Shared constants, register codes and inter-stage types of the trilinear grid interpolator.
package tgi_pkg;

	localparam int unsigned TABLE_DEPTH = 65536;
	localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
	// Wide enough for any corner address the grid registers can form.
	localparam int unsigned FULL_ADDR_W = 40;
	localparam logic [FULL_ADDR_W-1:0] DEPTH_FULL = FULL_ADDR_W'(TABLE_DEPTH);

	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 26;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LON_ORIGIN  = 4'd0,
		REG_LAT_ORIGIN  = 4'd1,
		REG_AZI_ORIGIN  = 4'd2,
		REG_GRID_INV    = 4'd3,
		REG_AZI_INV     = 4'd4,
		REG_LON_COUNT   = 4'd5,
		REG_LAT_COUNT   = 4'd6,
		REG_AZI_COUNT   = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [25:0] lon_origin;
		logic signed [23:0] lat_origin;
		logic [24:0]        azi_origin;
		logic [23:0]        grid_step_inverse;
		logic [23:0]        azi_step_inverse;
		logic [12:0]        lon_count;
		logic [12:0]        lat_count;
		logic [12:0]        azi_count;
		logic [25:0]        plane;      // lat_count * lon_count
	} cfg_t;

	// One item as it leaves the index pipeline.
	typedef struct packed {
		logic        cmd;
		logic [15:0] load_index;
		logic [15:0] load_value;
		logic        ok;
		logic [11:0] o0;
		logic [11:0] o1;
		logic [25:0] tt0;
		logic [25:0] tt1;
		logic [38:0] ta0;
		logic [38:0] ta1;
		logic [15:0] fo;
		logic [15:0] ft;
		logic [15:0] fa;
	} query_t;

	// One corner read, aligned with the table read data.
	typedef struct packed {
		logic        last;
		logic        bad;
		logic [16:0] wa;
		logic [33:0] wot;
	} corner_t;

	typedef struct packed {
		logic [15:0] land_fraction;
		logic        in_grid;
	} result_t;

endpackage

// ===== hdl/tgi_if.sv =====
// Handshake channels of the trilinear grid interpolator: items, results, register writes.
interface tgi_item_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [15:0]        load_index;
	logic [15:0]        load_value;
	logic signed [25:0] lon_deg;
	logic signed [23:0] lat_deg;
	logic [24:0]        azi_deg;

	modport source (output valid, cmd, load_index, load_value, lon_deg, lat_deg, azi_deg,
		input ready);
	modport sink (input valid, cmd, load_index, load_value, lon_deg, lat_deg, azi_deg,
		output ready);
endinterface

interface tgi_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] land_fraction;
	logic        in_grid;

	modport source (output valid, land_fraction, in_grid, input ready);
	modport sink (input valid, land_fraction, in_grid, output ready);
endinterface

interface tgi_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tgi_pkg::CFG_IDX_W-1:0]   index;
	logic [tgi_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/tgi_ram.sv =====
// Generic single-port RAM with registered read.
module tgi_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== hdl/tgi_front.sv =====
// Index pipeline: offset, scale, wrap and address partial products over five stages.
module tgi_front (
	input  logic            clk,
	input  logic            arst_n,
	tgi_item_if.sink        item,
	input  tgi_pkg::cfg_t   cfg,
	output logic            q_valid,
	output tgi_pkg::query_t q,
	input  logic            q_ready
);

	typedef struct packed {
		logic        cmd;
		logic [15:0] load_index;
		logic [15:0] load_value;
	} hdr_t;

	typedef struct packed {
		logic [15:0] lon;
		logic [15:0] lat;
		logic [15:0] azi;
	} frac_t;

	typedef struct packed {
		logic        ok;
		logic [11:0] i0;
		logic [11:0] i1;
	} wrap_t;

	function automatic wrap_t wrap_axis(input logic signed [19:0] idx, input logic [12:0] n);
		logic signed [20:0] i0;
		logic signed [20:0] i1;
		logic signed [20:0] nn;
		wrap_t r;
		nn = $signed({8'b0, n});
		i0 = $signed({idx[19], idx});
		if (i0 == -21'sd1) begin
			i0 = nn - 21'sd1;
		end else if (i0 == nn) begin
			i0 = 21'sd0;
		end
		i1 = i0 + 21'sd1;
		if (i1 == nn) begin
			i1 = 21'sd0;
		end
		r.ok = (i0 >= 21'sd0) && (i0 < nn) && (i1 >= 21'sd0) && (i1 < nn);
		r.i0 = i0[11:0];
		r.i1 = i1[11:0];
		return r;
	endfunction

	logic adv1, adv2, adv3, adv4, adv5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	hdr_t hdr_s1, hdr_s2, hdr_s3, hdr_s4;
	frac_t fr_s2, fr_s3, fr_s4;

	logic signed [26:0] dlon_s1;
	logic signed [24:0] dlat_s1;
	logic signed [25:0] dazi_s1;

	logic signed [19:0] ilon_s2, ilat_s2, iazi_s2;

	logic        ok_s3;
	logic [11:0] o0_s3, o1_s3, t0_s3, a0_s3, a1_s3;

	logic        ok_s4;
	logic [11:0] o0_s4, o1_s4, a1_s4;
	logic [25:0] tt0_s4;
	logic [38:0] ta0_s4;

	tgi_pkg::query_t q_s5;

	logic signed [51:0] plon;
	logic signed [49:0] plat;
	logic signed [50:0] pazi;
	wrap_t              wlon, wazi;
	logic signed [20:0] lat0;
	logic               lat_ok;
	logic [24:0]        tt_prod;
	logic [37:0]        ta_prod;

	assign adv5 = !v_s5 || q_ready;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign item.ready = adv1;

	assign plon = dlon_s1 * $signed({1'b0, cfg.grid_step_inverse});
	assign plat = dlat_s1 * $signed({1'b0, cfg.grid_step_inverse});
	assign pazi = dazi_s1 * $signed({1'b0, cfg.azi_step_inverse});

	assign wlon = wrap_axis(ilon_s2, cfg.lon_count);
	assign wazi = wrap_axis(iazi_s2, cfg.azi_count);
	assign lat0 = $signed({ilat_s2[19], ilat_s2});
	assign lat_ok = (lat0 >= 21'sd0) && ((lat0 + 21'sd1) < $signed({8'b0, cfg.lat_count}));

	assign tt_prod = t0_s3 * cfg.lon_count;
	assign ta_prod = a0_s3 * cfg.plane;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= item.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			hdr_s1  <= '{cmd: item.cmd, load_index: item.load_index,
				load_value: item.load_value};
			dlon_s1 <= $signed({item.lon_deg[25], item.lon_deg})
				- $signed({cfg.lon_origin[25], cfg.lon_origin});
			dlat_s1 <= $signed({item.lat_deg[23], item.lat_deg})
				- $signed({cfg.lat_origin[23], cfg.lat_origin});
			dazi_s1 <= $signed({1'b0, item.azi_deg}) - $signed({1'b0, cfg.azi_origin});
		end
		// Floor index is the integer part of the Q32 product, weight its top fraction bits.
		if (adv2) begin
			hdr_s2  <= hdr_s1;
			ilon_s2 <= plon[51:32];
			ilat_s2 <= {{2{plat[49]}}, plat[49:32]};
			iazi_s2 <= {pazi[50], pazi[50:32]};
			fr_s2   <= '{lon: plon[31:16], lat: plat[31:16], azi: pazi[31:16]};
		end
		if (adv3) begin
			hdr_s3 <= hdr_s2;
			fr_s3  <= fr_s2;
			ok_s3  <= wlon.ok && wazi.ok && lat_ok;
			o0_s3  <= wlon.i0;
			o1_s3  <= wlon.i1;
			t0_s3  <= ilat_s2[11:0];
			a0_s3  <= wazi.i0;
			a1_s3  <= wazi.i1;
		end
		if (adv4) begin
			hdr_s4 <= hdr_s3;
			fr_s4  <= fr_s3;
			ok_s4  <= ok_s3;
			o0_s4  <= o0_s3;
			o1_s4  <= o1_s3;
			a1_s4  <= a1_s3;
			tt0_s4 <= {1'b0, tt_prod};
			ta0_s4 <= {1'b0, ta_prod};
		end
		// Upper latitude row is one lon stride on; upper azimuth plane wraps to zero.
		if (adv5) begin
			q_s5.cmd        <= hdr_s4.cmd;
			q_s5.load_index <= hdr_s4.load_index;
			q_s5.load_value <= hdr_s4.load_value;
			q_s5.ok         <= ok_s4;
			q_s5.o0         <= o0_s4;
			q_s5.o1         <= o1_s4;
			q_s5.tt0        <= tt0_s4;
			q_s5.tt1        <= tt0_s4 + {13'b0, cfg.lon_count};
			q_s5.ta0        <= ta0_s4;
			q_s5.ta1        <= (a1_s4 == 12'd0) ? 39'd0 : ta0_s4 + {13'b0, cfg.plane};
			q_s5.fo         <= fr_s4.lon;
			q_s5.ft         <= fr_s4.lat;
			q_s5.fa         <= fr_s4.azi;
		end
	end

	assign q_valid = v_s5;
	assign q = q_s5;

endmodule

// ===== hdl/tgi_corner.sv =====
// Corner sequencer: owns the table port, writes loads, issues eight corner reads per query.
module tgi_corner (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  tgi_pkg::query_t  q,
	output logic             q_ready,
	input  logic             credit_ok,
	output logic             start,
	output logic             c_valid,
	output tgi_pkg::corner_t c,
	output logic [15:0]      rd_data
);

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'b01,
		SEQ_READ = 2'b10
	} seq_state_t;

	seq_state_t      state_q;
	logic [2:0]      k_q;
	logic            bad_q;
	tgi_pkg::query_t hq_q;

	logic            c_valid_s6;
	tgi_pkg::corner_t c_s6;

	logic is_idle, is_read, last_k, take, wr, ld_in_range, oob, bad_now;
	logic [tgi_pkg::FULL_ADDR_W-1:0] ld_full, caddr;
	logic [11:0] io;
	logic [25:0] tt;
	logic [38:0] ta;
	logic [16:0] wo, wt, wa;
	logic [33:0] wot;
	logic [tgi_pkg::ADDR_W-1:0] ram_addr;

	assign is_idle = (state_q == SEQ_IDLE);
	assign is_read = (state_q == SEQ_READ);
	assign last_k  = (k_q == 3'd7);

	// A load needs the port for its write, so it waits for the read burst to end.
	assign q_ready = (is_idle || (is_read && last_k))
		&& ((q.cmd == tgi_pkg::CMD_LOAD) ? is_idle : credit_ok);
	assign take  = q_valid && q_ready;
	assign start = take && (q.cmd == tgi_pkg::CMD_QUERY);

	assign ld_full     = {{(tgi_pkg::FULL_ADDR_W-16){1'b0}}, q.load_index};
	assign ld_in_range = ld_full < tgi_pkg::DEPTH_FULL;
	assign wr = take && (q.cmd == tgi_pkg::CMD_LOAD) && ld_in_range;

	assign io = k_q[2] ? hq_q.o1 : hq_q.o0;
	assign tt = k_q[1] ? hq_q.tt1 : hq_q.tt0;
	assign ta = k_q[0] ? hq_q.ta1 : hq_q.ta0;
	assign caddr = {{(tgi_pkg::FULL_ADDR_W-12){1'b0}}, io}
		+ {{(tgi_pkg::FULL_ADDR_W-26){1'b0}}, tt}
		+ {{(tgi_pkg::FULL_ADDR_W-39){1'b0}}, ta};
	assign oob     = caddr >= tgi_pkg::DEPTH_FULL;
	assign bad_now = bad_q || oob;

	assign wo  = k_q[2] ? {1'b0, hq_q.fo} : 17'h10000 - {1'b0, hq_q.fo};
	assign wt  = k_q[1] ? {1'b0, hq_q.ft} : 17'h10000 - {1'b0, hq_q.ft};
	assign wa  = k_q[0] ? {1'b0, hq_q.fa} : 17'h10000 - {1'b0, hq_q.fa};
	assign wot = wo * wt;

	assign ram_addr = wr ? ld_full[tgi_pkg::ADDR_W-1:0] : caddr[tgi_pkg::ADDR_W-1:0];

	tgi_ram #(
		.WIDTH(16),
		.DEPTH(tgi_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr),
		.re    (is_read),
		.addr  (ram_addr),
		.wdata (q.load_value),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_IDLE;
			k_q        <= 3'd0;
			bad_q      <= 1'b0;
			c_valid_s6 <= 1'b0;
		end else begin
			c_valid_s6 <= is_read;
			case (state_q)
				SEQ_IDLE: begin
					if (start) begin
						state_q <= SEQ_READ;
						k_q     <= 3'd0;
						bad_q   <= !q.ok;
					end
				end
				SEQ_READ: begin
					k_q   <= k_q + 3'd1;
					bad_q <= bad_now;
					if (last_k) begin
						if (start) begin
							bad_q <= !q.ok;
						end else begin
							state_q <= SEQ_IDLE;
						end
					end
				end
				default: begin
					state_q <= SEQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hq_q <= q;
		end
		if (is_read) begin
			c_s6 <= '{last: last_k, bad: bad_now, wa: wa, wot: wot};
		end
	end

	assign c_valid = c_valid_s6;
	assign c = c_s6;

endmodule

// ===== hdl/tgi_blend.sv =====
// Blend pipeline: weights each corner word, accumulates eight terms and rounds.
module tgi_blend (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             c_valid,
	input  tgi_pkg::corner_t c,
	input  logic [15:0]      rd_data,
	output logic             r_valid,
	output tgi_pkg::result_t r
);

	logic        v_s7, v_s8, v_s9, done_s10, r_valid_s11;
	logic        last_s7, last_s8, last_s9;
	logic        bad_s7, bad_s8, bad_s9, bad_s10;
	logic [33:0] wot_s7;
	logic [32:0] m_s7, m_s8;
	logic [16:0] wothi_s8;
	logic [49:0] pl_s8, pl_s9, ph_s9;
	logic [63:0] acc_q, term, rounded;
	logic        first_q;
	tgi_pkg::result_t r_s11;

	assign term    = {14'b0, pl_s9} + {ph_s9[46:0], 17'b0};
	assign rounded = acc_q + 64'h0000_8000_0000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			done_s10    <= 1'b0;
			r_valid_s11 <= 1'b0;
			first_q     <= 1'b1;
		end else begin
			v_s7        <= c_valid;
			v_s8        <= v_s7;
			v_s9        <= v_s8;
			done_s10    <= v_s9 && last_s9;
			r_valid_s11 <= done_s10;
			if (v_s9) begin
				first_q <= last_s9;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (c_valid) begin
			m_s7    <= rd_data * c.wa;
			wot_s7  <= c.wot;
			last_s7 <= c.last;
			bad_s7  <= c.bad;
		end
		if (v_s7) begin
			pl_s8    <= m_s7 * wot_s7[16:0];
			m_s8     <= m_s7;
			wothi_s8 <= wot_s7[33:17];
			last_s8  <= last_s7;
			bad_s8   <= bad_s7;
		end
		if (v_s8) begin
			ph_s9   <= m_s8 * wothi_s8;
			pl_s9   <= pl_s8;
			last_s9 <= last_s8;
			bad_s9  <= bad_s8;
		end
		if (v_s9) begin
			acc_q   <= (first_q ? 64'd0 : acc_q) + term;
			bad_s10 <= bad_s9;
		end
		if (done_s10) begin
			r_s11.land_fraction <= bad_s10 ? 16'd0 : rounded[63:48];
			r_s11.in_grid       <= !bad_s10;
		end
	end

	assign r_valid = r_valid_s11;
	assign r = r_s11;

endmodule

// ===== hdl/trilinear_grid_interpolator_unit.sv =====
// An accepted query passes the index pipeline, corner sequencer and blend pipeline in order.
// Its eight corner reads share the table port; the next query may start on the last read.
// Loads each take the table port for one write and give no result beat.
// Reset clears pipeline valids, the sequencer, the result queue and the credit count, and
// returns the configuration registers to their reset values; the table itself is not cleared.
module trilinear_grid_interpolator_unit (
	input  logic         clk,
	input  logic         arst_n,
	tgi_item_if.sink     item,
	tgi_result_if.source result,
	tgi_cfg_if.sink      cfg
);

	// Register file. Writes must come only while the block is idle; it does not enforce this.
	tgi_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lon_origin        <= -26'sd11796480;
			cfg_q.lat_origin        <= -24'sd5898240;
			cfg_q.azi_origin        <= 25'd0;
			cfg_q.grid_step_inverse <= 24'd65536;
			cfg_q.azi_step_inverse  <= 24'd65536;
			cfg_q.lon_count         <= 13'd64;
			cfg_q.lat_count         <= 13'd32;
			cfg_q.azi_count         <= 13'd32;
			cfg_q.plane             <= 26'd2048;
		end else begin
			// Plane stride is registered from the counts and follows a count write in the next cycle.
			cfg_q.plane <= cfg_q.lat_count * cfg_q.lon_count;
			if (cfg.valid) begin
				case (tgi_pkg::cfg_reg_t'(cfg.index))
					tgi_pkg::REG_LON_ORIGIN: cfg_q.lon_origin        <= cfg.data[25:0];
					tgi_pkg::REG_LAT_ORIGIN: cfg_q.lat_origin        <= cfg.data[23:0];
					tgi_pkg::REG_AZI_ORIGIN: cfg_q.azi_origin        <= cfg.data[24:0];
					tgi_pkg::REG_GRID_INV:   cfg_q.grid_step_inverse <= cfg.data[23:0];
					tgi_pkg::REG_AZI_INV:    cfg_q.azi_step_inverse  <= cfg.data[23:0];
					tgi_pkg::REG_LON_COUNT:  cfg_q.lon_count         <= cfg.data[12:0];
					tgi_pkg::REG_LAT_COUNT:  cfg_q.lat_count         <= cfg.data[12:0];
					tgi_pkg::REG_AZI_COUNT:  cfg_q.azi_count         <= cfg.data[12:0];
					default: begin
						// Drop writes to unmapped indexes.
					end
				endcase
			end
		end
	end

	assign cfg.ready = 1'b1;

	// Index pipeline: offsets, scaled Q32 positions, wrapping and stride products.
	logic            q_valid, q_ready;
	tgi_pkg::query_t q;

	tgi_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q       (q),
		.q_ready (q_ready)
	);

	// Corner sequencer. A query starts only while a result queue slot is reserved for it,
	// so the blend pipeline never has to stall.
	logic             credit_ok, start, c_valid;
	tgi_pkg::corner_t c;
	logic [15:0]      rd_data;

	tgi_corner u_corner (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q         (q),
		.q_ready   (q_ready),
		.credit_ok (credit_ok),
		.start     (start),
		.c_valid   (c_valid),
		.c         (c),
		.rd_data   (rd_data)
	);

	// Blend: one weighted corner term per cycle into an exact 64-bit sum, then round half up.
	logic             r_valid;
	tgi_pkg::result_t r;

	tgi_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.c_valid (c_valid),
		.c       (c),
		.rd_data (rd_data),
		.r_valid (r_valid),
		.r       (r)
	);

	// Two-entry result queue parts the pipeline from the result sink.
	tgi_pkg::result_t fifo_q [2];
	logic [1:0]       fifo_count_q;
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       pending_q;
	logic             pop;

	assign pop       = result.valid && result.ready;
	assign credit_ok = (pending_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_count_q <= 2'd0;
			wr_ptr_q     <= 1'b0;
			rd_ptr_q     <= 1'b0;
			pending_q    <= 2'd0;
		end else begin
			if (r_valid) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			// Advance the queue fill and the outstanding-query credit count.
			fifo_count_q <= fifo_count_q + {1'b0, r_valid} - {1'b0, pop};
			pending_q    <= pending_q + {1'b0, start} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (r_valid) begin
			fifo_q[wr_ptr_q] <= r;
		end
	end

	assign result.valid         = (fifo_count_q != 2'd0);
	assign result.land_fraction = fifo_q[rd_ptr_q].land_fraction;
	assign result.in_grid       = fifo_q[rd_ptr_q].in_grid;

`ifndef ASSERT_OFF
	a_queue_within_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count_q <= pending_q)
		else $error("result queue holds more beats than outstanding queries");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> (fifo_count_q != 2'd2))
		else $error("result written into a full queue");

	a_start_needs_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 2'd2) |-> !start)
		else $error("query started without a reserved result slot");
`endif

endmodule
